>>> sv/wmsd_pkg.sv
// ----------------------------------------------------------------------------
// wmsd_pkg: shared types and constants for the weighted mean / stddev block
// Beat payloads, the command to the shift-subtract unit, and fixed widths.
// ----------------------------------------------------------------------------
package wmsd_pkg;

    localparam int MAX_OBJECTS = 4096;
    localparam int COUNT_W     = 13;
    localparam int STEP_W      = 7;
    localparam int REM_W       = 41;
    localparam int DVS_W       = 40;
    localparam int QUO_W       = 64;
    localparam int ROOT_W      = 32;

    localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_OBJECTS);
    localparam logic [STEP_W-1:0]  STEPS_DIV  = STEP_W'(32);
    localparam logic [STEP_W-1:0]  STEPS_WIDE = STEP_W'(64);
    localparam logic [STEP_W-1:0]  STEPS_SQRT = STEP_W'(32);

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [15:0]        sample_weight;
        logic               object_active;
        logic               value_missing;
        logic               last_object;
    } sample_t;

    typedef struct packed {
        logic signed [31:0]   weighted_mean;
        logic [31:0]          weighted_stddev;
        logic [COUNT_W-1:0]   used_count;
    } result_t;

    typedef struct packed {
        logic              start;
        logic              sqrt_mode;
        logic [STEP_W-1:0] steps;
    } iter_cmd_t;

endpackage

>>> sv/wmsd_iter.sv
// ----------------------------------------------------------------------------
// wmsd_iter: shared shift-subtract unit
// Restoring division (one quotient bit per cycle) or digit-by-digit square
// root (one root bit per cycle), with one compare-subtract used for both.
// ----------------------------------------------------------------------------
module wmsd_iter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wmsd_pkg::iter_cmd_t            cmd,
    input  logic [wmsd_pkg::REM_W-1:0]     rem_init,
    input  logic [wmsd_pkg::QUO_W-1:0]     dvd_init,
    input  logic [wmsd_pkg::DVS_W-1:0]     dvs,
    output logic                           done,
    output logic [wmsd_pkg::QUO_W-1:0]     quo
);
    import wmsd_pkg::*;

    localparam int SUB_W = REM_W + 1;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_cnt_reg;
    logic              sqrt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [SUB_W-1:0]  a_op;
    logic [SUB_W-1:0]  b_op;
    logic [SUB_W:0]    diff;
    logic              ge;

    // In root mode the trial value is the partial root with "01" appended,
    // and two radicand bits are brought down each step.
    always_comb
    begin
        if (sqrt_reg)
        begin
            a_op = {rem_reg[REM_W-2:0], dvd_reg[QUO_W-1 -: 2]};
            b_op = SUB_W'({quo_reg[ROOT_W-1:0], 2'b01});
        end
        else
        begin
            a_op = {rem_reg, dvd_reg[QUO_W-1]};
            b_op = SUB_W'(dvs_reg);
        end
        diff = {1'b0, a_op} - {1'b0, b_op};
        ge   = ~diff[SUB_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            step_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= ~cmd.start & busy_reg & (step_cnt_reg == STEP_W'(1));
            if (cmd.start)
            begin
                busy_reg     <= 1'b1;
                step_cnt_reg <= cmd.steps;
            end
            else if (busy_reg)
            begin
                step_cnt_reg <= step_cnt_reg - STEP_W'(1);
                if (step_cnt_reg == STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sqrt_reg <= cmd.sqrt_mode;
            rem_reg  <= rem_init;
            dvd_reg  <= dvd_init;
            dvs_reg  <= dvs;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : a_op[REM_W-1:0];
            dvd_reg <= sqrt_reg ? {dvd_reg[QUO_W-3:0], 2'b00} : {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> sv/weighted_mean_stddev_missing_top.sv
// ----------------------------------------------------------------------------
// weighted_mean_stddev_missing_top: weighted mean and sample stddev of a run
// Accumulates used samples and emits mean, stddev and count on the last beat.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time; sample_ready is high only while the
// block waits for a beat. A skipped beat (inactive, missing, zero weight or
// beyond 4096 used samples) adds nothing to the sums, the first used sample
// of a run seeds them, and every further used sample runs two divisions with
// a 32-bit quotient by the running weight total on the shared shift-subtract
// unit (one bit per cycle) plus products on the shared 32x32 multiplier. A
// beat marked last then runs a division with a 32-bit quotient for the mean,
// one with a 64-bit quotient for the variance and a 32-bit square root (only
// the mean division for a run of one sample or none, and no variance division
// when its quotient saturates), then waits for the previous result to leave.
// The result sits in an output register, so the next run may start while it waits.
module weighted_mean_stddev_missing_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  wmsd_pkg::sample_t  sample,
    output logic               result_valid,
    input  logic               result_ready,
    output wmsd_pkg::result_t  result
);
    import wmsd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_XW,
        ST_ACC_XW,
        ST_F_START,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_F_WAIT,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_R_WAIT,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_FIN_START,
        ST_FN1,
        ST_FN2,
        ST_FN3,
        ST_MEAN_WAIT,
        ST_Q_WAIT,
        ST_S_WAIT,
        ST_EMIT
    } state_t;

    // Control and accumulated state
    state_t             state_reg, state_next;
    logic               started_reg;
    logic [63:0]        wsum_reg;
    logic [31:0]        wtot_reg;
    logic [47:0]        mean_reg;
    logic [63:0]        spread_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               result_valid_reg;

    // Working registers
    logic [31:0]        x_reg;
    logic [15:0]        w_reg;
    logic               last_reg;
    logic [31:0]        tot_reg;
    logic               dneg_reg;
    logic [47:0]        dmag_reg;
    logic [63:0]        prod_reg;
    logic [95:0]        sqacc_reg;
    logic [31:0]        f_reg;
    logic [31:0]        r_reg;
    logic [95:0]        tacc_reg;
    logic [63:0]        macc_reg;
    logic [47:0]        step_reg;
    logic [76:0]        nacc_reg;
    logic [DVS_W-1:0]   dq_reg;
    logic [31:0]        mean_out_reg;
    logic [31:0]        sd_reg;
    result_t            result_reg;

    // Combinational
    logic               accept;
    logic               use_sample;
    logic               emit_free;
    logic               many_samples;
    logic               q_overflow;
    logic [31:0]        x_mag;
    logic [47:0]        x_scaled;
    logic [48:0]        diff_ext;
    logic [48:0]        diff_neg;
    logic [47:0]        diff_mag;
    logic [63:0]        ws_mag;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [95:0]        mean_sum;
    logic [63:0]        term;
    logic [64:0]        spread_sum;
    logic [32:0]        q_ext;
    logic [32:0]        q_signed;
    logic [31:0]        mean_clamped;

    iter_cmd_t          iter_cmd;
    logic [REM_W-1:0]   iter_rem;
    logic [QUO_W-1:0]   iter_dvd;
    logic [DVS_W-1:0]   iter_dvs;
    logic               iter_done;
    logic [QUO_W-1:0]   iter_quo;

    wmsd_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (iter_cmd),
        .rem_init (iter_rem),
        .dvd_init (iter_dvd),
        .dvs      (iter_dvs),
        .done     (iter_done),
        .quo      (iter_quo)
    );

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid & sample_ready;
    assign use_sample   = sample.object_active & ~sample.value_missing
                          & (sample.sample_weight != 16'd0) & (count_reg < MAX_COUNT);
    assign emit_free    = ~result_valid_reg | result_ready;
    assign many_samples = (count_reg > COUNT_W'(1));

    assign x_mag    = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign x_scaled = {x_reg, 16'h0000};
    assign diff_ext = {x_scaled[47], x_scaled} - {mean_reg[47], mean_reg};
    assign diff_neg = ~diff_ext + 49'd1;
    assign diff_mag = diff_ext[48] ? diff_neg[47:0] : diff_ext[47:0];
    assign ws_mag   = wsum_reg[63] ? (~wsum_reg + 64'd1) : wsum_reg;

    assign mean_sum   = {32'h0, macc_reg} + {prod_reg, 32'h0};
    assign term       = (tacc_reg[95:80] != 16'h0) ? '1 : tacc_reg[79:16];
    assign spread_sum = {1'b0, spread_reg} + {1'b0, term};
    assign q_overflow = ({27'h0, nacc_reg[76:64]} >= dq_reg);

    // Mean from the magnitude quotient, truncated toward zero.
    always_comb
    begin
        q_ext    = {1'b0, iter_quo[31:0]};
        q_signed = wsum_reg[63] ? (~q_ext + 33'd1) : q_ext;
        if (wtot_reg == 32'h0)
            mean_clamped = '0;
        else if (!wsum_reg[63] && q_ext > 33'h0_7FFF_FFFF)
            mean_clamped = 32'h7FFF_FFFF;
        else if (wsum_reg[63] && q_ext > 33'h0_8000_0000)
            mean_clamped = 32'h8000_0000;
        else
            mean_clamped = q_signed[31:0];
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_XW:
            begin
                mul_a = x_mag;
                mul_b = {16'h0, w_reg};
            end
            ST_ACC_XW:
            begin
                mul_a = wtot_reg;
                mul_b = {16'h0, w_reg};
            end
            ST_F_START:
            begin
                mul_a = dmag_reg[31:0];
                mul_b = dmag_reg[31:0];
            end
            ST_SQ1:
            begin
                mul_a = dmag_reg[31:0];
                mul_b = {16'h0, dmag_reg[47:32]};
            end
            ST_SQ2:
            begin
                mul_a = {16'h0, dmag_reg[47:32]};
                mul_b = {16'h0, dmag_reg[47:32]};
            end
            ST_F_WAIT:
            begin
                mul_a = sqacc_reg[63:32];
                mul_b = iter_quo[31:0];
            end
            ST_T1:
            begin
                mul_a = sqacc_reg[95:64];
                mul_b = f_reg;
            end
            ST_R_WAIT:
            begin
                mul_a = dmag_reg[31:0];
                mul_b = iter_quo[31:0];
            end
            ST_M1:
            begin
                mul_a = {16'h0, dmag_reg[47:32]};
                mul_b = r_reg;
            end
            ST_FIN_START:
            begin
                mul_a = spread_reg[31:0];
                mul_b = 32'(count_reg);
            end
            ST_FN1:
            begin
                mul_a = spread_reg[63:32];
                mul_b = 32'(count_reg);
            end
            ST_FN2:
            begin
                mul_a = wtot_reg;
                mul_b = 32'(count_reg - COUNT_W'(1));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'h0, mul_a} * {32'h0, mul_b};

    // Commands to the shift-subtract unit.
    always_comb
    begin
        iter_cmd = '0;
        iter_rem = '0;
        iter_dvd = '0;
        iter_dvs = '0;
        case (state_reg)
            ST_F_START:
            begin
                // f = W*w*2^16 / T
                iter_cmd.start = 1'b1;
                iter_cmd.steps = STEPS_DIV;
                iter_rem       = REM_W'(prod_reg[63:16]);
                iter_dvd       = {prod_reg[15:0], 48'h0};
                iter_dvs       = DVS_W'(tot_reg);
            end
            ST_F_WAIT:
            begin
                // r = w*2^32 / T
                if (iter_done)
                begin
                    iter_cmd.start = 1'b1;
                    iter_cmd.steps = STEPS_DIV;
                    iter_rem       = REM_W'(w_reg);
                    iter_dvs       = DVS_W'(tot_reg);
                end
            end
            ST_FIN_START:
            begin
                iter_cmd.start = 1'b1;
                iter_cmd.steps = STEPS_DIV;
                iter_rem       = REM_W'(ws_mag[63:32]);
                iter_dvd       = {ws_mag[31:0], 32'h0};
                iter_dvs       = DVS_W'(wtot_reg);
            end
            ST_MEAN_WAIT:
            begin
                if (iter_done && many_samples)
                begin
                    iter_cmd.start = 1'b1;
                    if (q_overflow)
                    begin
                        // Variance quotient saturates; go straight to the root.
                        iter_cmd.sqrt_mode = 1'b1;
                        iter_cmd.steps     = STEPS_SQRT;
                        iter_dvd           = '1;
                    end
                    else
                    begin
                        iter_cmd.steps = STEPS_WIDE;
                        iter_rem       = REM_W'(nacc_reg[76:64]);
                        iter_dvd       = nacc_reg[63:0];
                        iter_dvs       = dq_reg;
                    end
                end
            end
            ST_Q_WAIT:
            begin
                if (iter_done)
                begin
                    iter_cmd.start     = 1'b1;
                    iter_cmd.sqrt_mode = 1'b1;
                    iter_cmd.steps     = STEPS_SQRT;
                    iter_dvd           = iter_quo;
                end
            end
            default:
            begin
                iter_cmd = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (use_sample)
                        state_next = ST_MUL_XW;
                    else if (sample.last_object)
                        state_next = ST_FIN_START;
                end
            end
            ST_MUL_XW:    state_next = ST_ACC_XW;
            ST_ACC_XW:
            begin
                if (started_reg)
                    state_next = ST_F_START;
                else if (last_reg)
                    state_next = ST_FIN_START;
                else
                    state_next = ST_IDLE;
            end
            ST_F_START:   state_next = ST_SQ1;
            ST_SQ1:       state_next = ST_SQ2;
            ST_SQ2:       state_next = ST_SQ3;
            ST_SQ3:       state_next = ST_F_WAIT;
            ST_F_WAIT:    state_next = iter_done ? ST_T1 : ST_F_WAIT;
            ST_T1:        state_next = ST_T2;
            ST_T2:        state_next = ST_T3;
            ST_T3:        state_next = ST_R_WAIT;
            ST_R_WAIT:    state_next = iter_done ? ST_M1 : ST_R_WAIT;
            ST_M1:        state_next = ST_M2;
            ST_M2:        state_next = ST_M3;
            ST_M3:        state_next = last_reg ? ST_FIN_START : ST_IDLE;
            ST_FIN_START: state_next = ST_FN1;
            ST_FN1:       state_next = ST_FN2;
            ST_FN2:       state_next = ST_FN3;
            ST_FN3:       state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
            begin
                if (iter_done)
                begin
                    if (!many_samples)
                        state_next = ST_EMIT;
                    else if (q_overflow)
                        state_next = ST_S_WAIT;
                    else
                        state_next = ST_Q_WAIT;
                end
            end
            ST_Q_WAIT:    state_next = iter_done ? ST_S_WAIT : ST_Q_WAIT;
            ST_S_WAIT:    state_next = iter_done ? ST_EMIT : ST_S_WAIT;
            ST_EMIT:      state_next = emit_free ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            started_reg      <= 1'b0;
            wsum_reg         <= '0;
            wtot_reg         <= '0;
            mean_reg         <= '0;
            spread_reg       <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && emit_free)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            case (state_reg)
                ST_ACC_XW:
                begin
                    wsum_reg <= x_reg[31] ? (wsum_reg - prod_reg) : (wsum_reg + prod_reg);
                    if (!started_reg)
                    begin
                        started_reg <= 1'b1;
                        mean_reg    <= x_scaled;
                        spread_reg  <= '0;
                        wtot_reg    <= wtot_reg + 32'(w_reg);
                        count_reg   <= count_reg + COUNT_W'(1);
                    end
                end
                ST_T3:
                begin
                    spread_reg <= spread_sum[64] ? '1 : spread_sum[63:0];
                end
                ST_M3:
                begin
                    mean_reg  <= dneg_reg ? (mean_reg - step_reg) : (mean_reg + step_reg);
                    wtot_reg  <= tot_reg;
                    count_reg <= count_reg + COUNT_W'(1);
                end
                ST_EMIT:
                begin
                    if (emit_free)
                    begin
                        started_reg      <= 1'b0;
                        wsum_reg         <= '0;
                        wtot_reg         <= '0;
                        mean_reg         <= '0;
                        spread_reg       <= '0;
                        count_reg        <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_reg    <= sample.sample_value;
                    w_reg    <= sample.sample_weight;
                    last_reg <= sample.last_object;
                end
            end
            ST_ACC_XW:
            begin
                tot_reg  <= wtot_reg + 32'(w_reg);
                dneg_reg <= diff_ext[48];
                dmag_reg <= diff_mag;
            end
            // The square of the mean offset is built from three partial products.
            ST_SQ1:       sqacc_reg <= {32'h0, prod_reg};
            ST_SQ2:       sqacc_reg <= sqacc_reg + ({32'h0, prod_reg} << 33);
            ST_SQ3:       sqacc_reg <= sqacc_reg + ({32'h0, prod_reg} << 64);
            ST_F_WAIT:
            begin
                if (iter_done)
                    f_reg <= iter_quo[31:0];
            end
            ST_T1:        tacc_reg <= {32'h0, prod_reg};
            ST_T2:        tacc_reg <= tacc_reg + {prod_reg, 32'h0};
            ST_R_WAIT:
            begin
                if (iter_done)
                    r_reg <= iter_quo[31:0];
            end
            ST_M1:        macc_reg <= prod_reg;
            ST_M2:        step_reg <= mean_sum[79:32];
            ST_FN1:       nacc_reg <= 77'(prod_reg);
            ST_FN2:       nacc_reg <= nacc_reg + (77'(prod_reg) << 32);
            ST_FN3:       dq_reg   <= prod_reg[DVS_W-1:0];
            ST_MEAN_WAIT:
            begin
                if (iter_done)
                begin
                    mean_out_reg <= mean_clamped;
                    if (!many_samples)
                        sd_reg <= '0;
                end
            end
            ST_S_WAIT:
            begin
                if (iter_done)
                    sd_reg <= iter_quo[31:0];
            end
            ST_EMIT:
            begin
                if (emit_free)
                begin
                    result_reg.weighted_mean   <= mean_out_reg;
                    result_reg.weighted_stddev <= sd_reg;
                    result_reg.used_count      <= count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> sv/wmsd_checker.sv
// ----------------------------------------------------------------------------
// wmsd_checker: port-level checks for the weighted mean / stddev block
// Watches the sample and result beats and is bound to the top level below.
// ----------------------------------------------------------------------------
module wmsd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_ready,
    input wmsd_pkg::sample_t  sample,
    input logic               result_valid,
    input logic               result_ready,
    input wmsd_pkg::result_t  result
);
    import wmsd_pkg::*;

    // A stalled sample beat keeps its payload.
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample))
        else $error("sample beat changed while stalled");

    // A stalled result beat keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.used_count <= MAX_COUNT)
        else $error("used count exceeds the run limit");

    // With one sample or none there is no spread to report.
    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.used_count <= COUNT_W'(1) |-> result.weighted_stddev == 32'h0)
        else $error("nonzero stddev with fewer than two samples");

    a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.used_count == '0 |-> result.weighted_mean == 32'sh0)
        else $error("nonzero mean for an empty run");

endmodule

bind weighted_mean_stddev_missing_top wmsd_checker u_wmsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
